>>> design/crr_pkg.sv
package crr_pkg;

    localparam int BUF_LEN_DEF = 64;
    localparam int SLOTS_DEF   = 16;

    // Frame layout: six header bytes, name from byte eight on.
    localparam int HDR_BYTES  = 6;
    localparam int NAME_START = 8;

    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_ONE  = 8'h31;

    localparam logic [1:0] KIND_NAME    = 2'd0;
    localparam logic [1:0] KIND_RESTART = 2'd1;
    localparam logic [1:0] KIND_CLEAR   = 2'd2;

    // 0.8 = 4/5; floor(m * 4 / 5) equals (m * 0xCCCD) >> 16 for any 16-bit m.
    localparam logic [15:0] RECIP_FIVE = 16'hCCCD;
    localparam logic signed [16:0] X_OFFSET = 17'sd624;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HDR_RD,
        ST_HDR_WAIT,
        ST_MATH,
        ST_SCALE,
        ST_SPEC_OUT,
        ST_NAME_WAIT,
        ST_NAME_OUT,
        ST_FINISH
    } crr_state_t;

    typedef struct packed {
        logic store_rx;
        logic store_first;
        logic start_frame;
        logic hdr_rd;
        logic math;
        logic scale;
        logic load_special;
        logic name_start;
        logic load_name;
        logic name_next;
        logic finish;
    } crr_cmd_t;

    typedef struct packed {
        logic rx_cr;
        logic rx_lf;
        logic hdr_last;
        logic special;
        logic out_take;
        logic out_last;
    } crr_status_t;

endpackage

>>> design/crr_ram.sv
module crr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/crr_ctrl.sv
module crr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  crr_pkg::crr_status_t stat,
    output crr_pkg::crr_cmd_t    cmd
);

    crr_pkg::crr_state_t state_reg, state_next;
    logic cr_seen_reg, cr_seen_next;
    logic frame_done_reg, frame_done_next;
    logic accept;

    assign s_tready = (state_reg == crr_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= crr_pkg::ST_IDLE;
            cr_seen_reg    <= 1'b0;
            frame_done_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cr_seen_reg    <= cr_seen_next;
            frame_done_reg <= frame_done_next;
        end
    end

    always_comb begin
        cr_seen_next    = cr_seen_reg;
        frame_done_next = frame_done_reg;
        if (accept) begin
            if (frame_done_reg) begin
                cr_seen_next    = 1'b0;
                frame_done_next = 1'b0;
            end else if (cr_seen_reg) begin
                // A good ending waits for one more byte; a bad one resumes at once.
                if (stat.rx_lf) begin
                    frame_done_next = 1'b1;
                end else begin
                    cr_seen_next = 1'b0;
                end
            end else if (stat.rx_cr) begin
                cr_seen_next = 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            crr_pkg::ST_IDLE: begin
                if (accept && !frame_done_reg && cr_seen_reg) begin
                    state_next = crr_pkg::ST_HDR_RD;
                end
            end
            crr_pkg::ST_HDR_RD: begin
                if (stat.hdr_last) begin
                    state_next = crr_pkg::ST_HDR_WAIT;
                end
            end
            crr_pkg::ST_HDR_WAIT: state_next = crr_pkg::ST_MATH;
            crr_pkg::ST_MATH:     state_next = crr_pkg::ST_SCALE;
            crr_pkg::ST_SCALE: begin
                state_next = stat.special ? crr_pkg::ST_SPEC_OUT : crr_pkg::ST_NAME_WAIT;
            end
            crr_pkg::ST_SPEC_OUT: begin
                if (stat.out_take) begin
                    state_next = crr_pkg::ST_FINISH;
                end
            end
            crr_pkg::ST_NAME_WAIT: state_next = crr_pkg::ST_NAME_OUT;
            crr_pkg::ST_NAME_OUT: begin
                if (stat.out_take) begin
                    state_next = stat.out_last ? crr_pkg::ST_FINISH : crr_pkg::ST_NAME_WAIT;
                end
            end
            crr_pkg::ST_FINISH: state_next = crr_pkg::ST_IDLE;
            default:            state_next = crr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            crr_pkg::ST_IDLE: begin
                if (accept) begin
                    if (frame_done_reg) begin
                        cmd.store_first = 1'b1;
                    end else if (cr_seen_reg) begin
                        cmd.start_frame = 1'b1;
                    end else if (!stat.rx_cr) begin
                        cmd.store_rx = 1'b1;
                    end
                end
            end
            crr_pkg::ST_HDR_RD: cmd.hdr_rd = 1'b1;
            crr_pkg::ST_MATH:   cmd.math   = 1'b1;
            crr_pkg::ST_SCALE: begin
                cmd.scale = 1'b1;
                if (stat.special) begin
                    cmd.load_special = 1'b1;
                end else begin
                    cmd.name_start = 1'b1;
                end
            end
            crr_pkg::ST_NAME_WAIT: cmd.load_name = 1'b1;
            crr_pkg::ST_NAME_OUT: begin
                if (stat.out_take && !stat.out_last) begin
                    cmd.name_next = 1'b1;
                end
            end
            crr_pkg::ST_FINISH: cmd.finish = 1'b1;
            default: cmd = '0;
        endcase
    end

endmodule

>>> design/crr_datapath.sv
module crr_datapath #(
    parameter int BUF_LEN = crr_pkg::BUF_LEN_DEF,
    parameter int SLOTS   = crr_pkg::SLOTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  crr_pkg::crr_cmd_t    cmd,
    output crr_pkg::crr_status_t stat,
    input  logic [7:0]           rx_byte,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [1:0]           out_kind,
    output logic [3:0]           out_slot,
    output logic signed [16:0]   out_x_pos,
    output logic [15:0]          out_y_pos,
    output logic [7:0]           out_flag_byte,
    output logic [7:0]           out_type_byte,
    output logic [5:0]           out_name_pos,
    output logic [7:0]           out_name_byte,
    output logic                 out_line_ok,
    output logic                 out_last
);

    localparam int AW = $clog2(BUF_LEN);
    localparam int SW = $clog2(SLOTS);
    localparam int HW = $clog2(crr_pkg::HDR_BYTES);

    logic [AW-1:0]      byte_count_reg, byte_count_next;
    logic [BUF_LEN-1:0] valid_reg, valid_next;
    logic [SW-1:0]      slot_reg, slot_next;
    logic [HW-1:0]      hdr_idx_reg;
    logic               cap_reg;
    logic [HW-1:0]      cap_idx_reg;
    logic [7:0]         hdr_reg [crr_pkg::HDR_BYTES];
    logic               rd_valid_reg;
    logic [AW-1:0]      name_idx_reg;
    logic               line_ok_reg;
    logic [31:0]        prod_x_reg, prod_y_reg;
    logic               neg_reg;
    logic signed [16:0] x_reg;
    logic [15:0]        y_reg;
    logic               out_valid_reg;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [7:0]         ram_rdata, rd_byte;
    logic               is_restart, is_clear, name_last;
    logic signed [16:0] vx;
    logic [15:0]        x_mag;
    logic [15:0]        q_x;

    assign ram_we    = cmd.store_rx || cmd.store_first;
    assign ram_waddr = cmd.store_first ? '0 : byte_count_reg;
    assign ram_re    = cmd.hdr_rd || cmd.name_start || cmd.name_next;

    always_comb begin
        if (cmd.name_next) begin
            ram_raddr = name_idx_reg + AW'(1);
        end else if (cmd.name_start) begin
            ram_raddr = AW'(crr_pkg::NAME_START);
        end else begin
            ram_raddr = AW'(hdr_idx_reg);
        end
    end

    crr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_LEN)
    ) u_line_buf (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // An entry not written since the last frame reads as zero.
    assign rd_byte = rd_valid_reg ? ram_rdata : 8'h00;

    assign is_restart = (hdr_reg[0] == crr_pkg::CH_ZERO) && (hdr_reg[1] == crr_pkg::CH_ZERO) &&
                        (hdr_reg[2] == crr_pkg::CH_ZERO) && (hdr_reg[3] == crr_pkg::CH_ZERO);
    assign is_clear   = (hdr_reg[0] == crr_pkg::CH_ONE) && (hdr_reg[1] == crr_pkg::CH_ONE) &&
                        (hdr_reg[2] == crr_pkg::CH_ONE) && (hdr_reg[3] == crr_pkg::CH_ONE);

    assign name_last = (name_idx_reg == AW'(BUF_LEN - 1)) ||
                       ((name_idx_reg != AW'(crr_pkg::NAME_START)) && (rd_byte == 8'h00));

    assign vx    = $signed({1'b0, hdr_reg[1], hdr_reg[0]}) - crr_pkg::X_OFFSET;
    assign x_mag = vx[16] ? 16'(-vx) : vx[15:0];
    assign q_x   = prod_x_reg[31:16];

    assign stat.rx_cr    = (rx_byte == crr_pkg::CH_CR);
    assign stat.rx_lf    = (rx_byte == crr_pkg::CH_LF);
    assign stat.hdr_last = (hdr_idx_reg == HW'(crr_pkg::HDR_BYTES - 1));
    assign stat.special  = is_restart || is_clear;
    assign stat.out_take = out_valid_reg && out_ready;
    assign stat.out_last = out_last;

    always_comb begin
        byte_count_next = byte_count_reg;
        if (cmd.store_first) begin
            byte_count_next = AW'(1);
        end else if (cmd.store_rx) begin
            byte_count_next = (byte_count_reg == AW'(BUF_LEN - 1)) ? '0
                                                                  : byte_count_reg + AW'(1);
        end else if (cmd.start_frame && !stat.rx_lf) begin
            byte_count_next = '0;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (cmd.finish) begin
            valid_next = '0;
        end else if (ram_we) begin
            valid_next[ram_waddr] = 1'b1;
        end
    end

    always_comb begin
        slot_next = slot_reg;
        if (cmd.finish) begin
            if (is_clear) begin
                slot_next = '0;
            end else if (!is_restart) begin
                slot_next = (slot_reg == SW'(SLOTS - 1)) ? '0 : slot_reg + SW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            valid_reg      <= '0;
            slot_reg       <= SW'(1);
            hdr_idx_reg    <= '0;
            cap_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            byte_count_reg <= byte_count_next;
            valid_reg      <= valid_next;
            slot_reg       <= slot_next;
            cap_reg        <= cmd.hdr_rd;
            if (cmd.start_frame) begin
                hdr_idx_reg <= '0;
            end else if (cmd.hdr_rd) begin
                hdr_idx_reg <= hdr_idx_reg + HW'(1);
            end
            if (cmd.load_special || cmd.load_name) begin
                out_valid_reg <= 1'b1;
            end else if (stat.out_take) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cap_idx_reg  <= hdr_idx_reg;
        rd_valid_reg <= valid_reg[ram_raddr];
        if (cap_reg) begin
            hdr_reg[cap_idx_reg] <= rd_byte;
        end
        if (cmd.start_frame) begin
            line_ok_reg <= stat.rx_lf;
        end
        if (cmd.math) begin
            prod_x_reg <= x_mag * crr_pkg::RECIP_FIVE;
            prod_y_reg <= {hdr_reg[3], hdr_reg[2]} * crr_pkg::RECIP_FIVE;
            neg_reg    <= vx[16];
        end
        if (cmd.scale) begin
            x_reg <= neg_reg ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
            y_reg <= prod_y_reg[31:16];
        end
        if (cmd.name_start) begin
            name_idx_reg <= AW'(crr_pkg::NAME_START);
        end else if (cmd.name_next) begin
            name_idx_reg <= name_idx_reg + AW'(1);
        end
        if (cmd.load_special) begin
            out_kind      <= is_restart ? crr_pkg::KIND_RESTART : crr_pkg::KIND_CLEAR;
            out_slot      <= is_restart ? 4'd0 : 4'(slot_reg);
            out_x_pos     <= '0;
            out_y_pos     <= '0;
            out_flag_byte <= '0;
            out_type_byte <= '0;
            out_name_pos  <= '0;
            out_name_byte <= '0;
            out_line_ok   <= line_ok_reg;
            out_last      <= 1'b1;
        end else if (cmd.load_name) begin
            out_kind      <= crr_pkg::KIND_NAME;
            out_slot      <= 4'(slot_reg);
            out_x_pos     <= x_reg;
            out_y_pos     <= y_reg;
            out_flag_byte <= hdr_reg[4];
            out_type_byte <= hdr_reg[5];
            out_name_pos  <= 6'(name_idx_reg) - 6'(crr_pkg::NAME_START);
            out_name_byte <= rd_byte;
            out_line_ok   <= line_ok_reg;
            out_last      <= name_last;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> design/crlf_record_receiver_top.sv
// Line receiver for CR LF terminated binary records. Each accepted word on the
// s_ side is one received byte. An ordinary byte, or the CR, is accepted without
// closing the port. The byte after CR ends the frame, after which the port
// stays closed while the frame is decoded: six buffer reads for the header
// (one per cycle through the single read port of the line buffer), then the
// HDR_WAIT, MATH and SCALE states to collect the last header byte, scale and
// dispatch, then one result per name byte through the NAME_WAIT and NAME_OUT
// states, and the FINISH state to clear the buffer and update the slot counter.
// Restart and clear frames give one result word through the SPEC_OUT state.
// Back-pressure on m_tready holds each result word until it is taken.
module crlf_record_receiver_top #(
    parameter int BUF_LEN = crr_pkg::BUF_LEN_DEF,
    parameter int SLOTS   = crr_pkg::SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // slot[3:0], x_pos[20:4], y_pos[36:21], flag_byte[44:37], type_byte[52:45],
    // name_pos[58:53], name_byte[66:59], zero[71:67]
    output logic [71:0] m_tdata,
    output logic [2:0]  m_tuser,   // kind[1:0], line_ok[2]
    output logic        m_tlast
);

    crr_pkg::crr_cmd_t    cmd;
    crr_pkg::crr_status_t stat;

    logic [1:0]         kind;
    logic [3:0]         slot;
    logic signed [16:0] x_pos;
    logic [15:0]        y_pos;
    logic [7:0]         flag_byte, type_byte, name_byte;
    logic [5:0]         name_pos;
    logic               line_ok;

    crr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    crr_datapath #(
        .BUF_LEN (BUF_LEN),
        .SLOTS   (SLOTS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .rx_byte       (s_tdata),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_kind      (kind),
        .out_slot      (slot),
        .out_x_pos     (x_pos),
        .out_y_pos     (y_pos),
        .out_flag_byte (flag_byte),
        .out_type_byte (type_byte),
        .out_name_pos  (name_pos),
        .out_name_byte (name_byte),
        .out_line_ok   (line_ok),
        .out_last      (m_tlast)
    );

    assign m_tdata = {5'b0, name_byte, name_pos, type_byte, flag_byte, y_pos, x_pos, slot};
    assign m_tuser = {line_ok, kind};

endmodule

>>> design/crr_checker.sv
module crr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // The input is closed while any result of a frame is pending.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result word is pending");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    // Restart and clear frames give a single word.
    a_cmd_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] != crr_pkg::KIND_NAME) |-> m_tlast)
        else $error("command result without tlast");

    // More name words follow, so the input must stay closed.
    a_frame_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> !s_tready)
        else $error("input reopened in the middle of a frame");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result word changed");

endmodule

bind crlf_record_receiver_top crr_checker u_crr_checker (.*);
